// File: rtl/ntr_pkg.sv
// Shared types, constants and arithmetic helpers for the thermal time response pipeline.
package ntr_pkg;

    localparam int TEMP_W = 15;
    localparam int LOG_FRAC_BITS = 16;
    localparam int F = LOG_FRAC_BITS;
    localparam int EXP_W = 4;
    localparam int LOG_W = EXP_W + F;
    localparam int MANT_W = 31;
    localparam int Q = MANT_W - 1;
    localparam int QW = F + 6;
    localparam int REM_W = LOG_W + F;
    localparam int NW = $clog2(F + 2);
    localparam int YW = F + 2;
    localparam int FW = 2 * F + 2;

    localparam logic [QW-1:0] Q_ONE = QW'(1) << F;
    localparam logic [QW-1:0] Q_LIM = QW'(F + 1) << F;
    localparam logic [YW-1:0] Y_TWO = YW'(2) << F;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_CONFIG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE = 2'd0,
        REG_OPT  = 2'd1,
        REG_MAX  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        Y_EXP  = 2'd0,
        Y_ZERO = 2'd1,
        Y_TWO_SAT = 2'd2
    } ymode_t;

    typedef struct packed {
        status_t             status;
        logic [TEMP_W-1:0]   d;
    } ctx_t;

    typedef struct packed {
        ymode_t              mode;
        logic [NW-1:0]       n;
        ctx_t                ctx;
    } ectx_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic [F:1][MANT_W-1:0] exp_table();
        logic [F:1][MANT_W-1:0] tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 1; j <= F; j++) begin
            tab[j] = c[MANT_W-1:0];
            c = isqrt64(c << Q);
        end
        return tab;
    endfunction

    localparam logic [F:1][MANT_W-1:0] EXP_C = exp_table();

    // Returns the emitted fraction bit above the new mantissa.
    function automatic logic [MANT_W:0] log_square(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        logic [MANT_W:0] s;
        p = (2*MANT_W)'(m) * (2*MANT_W)'(m);
        s = p[MANT_W+Q:Q];
        if (s[MANT_W]) begin
            return {1'b1, s[MANT_W:1]};
        end
        return {1'b0, s[MANT_W-1:0]};
    endfunction

    function automatic logic [MANT_W-1:0] exp_mul(input logic [MANT_W-1:0] y,
                                                 input logic [MANT_W-1:0] c);
        logic [2*MANT_W-1:0] p;
        p = (2*MANT_W)'(y) * (2*MANT_W)'(c);
        return p[MANT_W+Q-1:Q];
    endfunction

endpackage

// File: rtl/ntr_log2_unit.sv
// Three-lane pipelined log2 unit, one mantissa squaring per stage.
module ntr_log2_unit
    import ntr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [2:0][TEMP_W-1:0]      in_v,
    input  ctx_t                        in_ctx,
    output logic                        out_valid,
    output logic [2:0][LOG_W-1:0]       out_log,
    output ctx_t                        out_ctx
);

    logic [F:0]                     valid_reg;
    logic [2:0][EXP_W-1:0]          e_reg    [0:F];
    logic [2:0][F-1:0]              frac_reg [0:F];
    logic [2:0][MANT_W-1:0]         m_reg    [0:F-1];
    ctx_t                           ctx_reg  [0:F];

    logic [2:0][EXP_W-1:0]          e_next;
    logic [2:0][MANT_W-1:0]         m0_next;
    logic [2:0][MANT_W-1:0]         m_next   [1:F-1];
    logic [2:0][F-1:0]              frac_next[1:F];
    logic [MANT_W:0]                sq;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            e_next[l] = '0;
            for (int i = 1; i < TEMP_W; i++) begin
                if (in_v[l][i]) begin
                    e_next[l] = EXP_W'(i);
                end
            end
            m0_next[l] = MANT_W'(in_v[l]) << (Q - int'(e_next[l]));
        end
    end

    always_comb begin
        sq = '0;
        for (int k = 1; k < F; k++) begin
            m_next[k] = '0;
        end
        for (int k = 1; k <= F; k++) begin
            for (int l = 0; l < 3; l++) begin
                sq = log_square(m_reg[k-1][l]);
                if (k < F) begin
                    m_next[k][l] = sq[MANT_W-1:0];
                end
                frac_next[k][l] = {frac_reg[k-1][l][F-2:0], sq[MANT_W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[F-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg[0]    <= e_next;
            m_reg[0]    <= m0_next;
            frac_reg[0] <= '0;
            ctx_reg[0]  <= in_ctx;
            for (int k = 1; k <= F; k++) begin
                e_reg[k]    <= e_reg[k-1];
                frac_reg[k] <= frac_next[k];
                ctx_reg[k]  <= ctx_reg[k-1];
                if (k < F) begin
                    m_reg[k] <= m_next[k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            out_log[l] = {e_reg[F][l], frac_reg[F][l]};
        end
    end

    assign out_valid = valid_reg[F];
    assign out_ctx   = ctx_reg[F];

endmodule

// File: rtl/ntr_div_unit.sv
// Pipelined restoring divider for the exponent quotient, one quotient bit per stage.
module ntr_div_unit
    import ntr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [LOG_W-1:0]    in_mag,
    input  logic [LOG_W-1:0]    in_den,
    input  logic                in_neg,
    input  ctx_t                in_ctx,
    output logic                out_valid,
    output logic [QW-1:0]       out_q,
    output logic                out_neg,
    output ctx_t                out_ctx
);

    localparam int OVW = LOG_W + QW - F;
    localparam int SW = REM_W + QW;

    logic [QW:0]            valid_reg;
    logic [REM_W-1:0]       rem_reg [0:QW-1];
    logic [QW-1:0]          q_reg   [0:QW];
    logic [LOG_W-1:0]       den_reg [0:QW];
    logic                   neg_reg [0:QW];
    logic                   ovf_reg [0:QW];
    ctx_t                   ctx_reg [0:QW];

    logic                   ovf_next;
    logic [REM_W-1:0]       rem_next [1:QW-1];
    logic [QW-1:0]          q_next   [1:QW];
    logic [SW-1:0]          sub;

    assign ovf_next = OVW'(in_mag) >= (OVW'(in_den) << (QW - F));

    always_comb begin
        sub = '0;
        for (int s = 1; s < QW; s++) begin
            rem_next[s] = '0;
        end
        for (int s = 1; s <= QW; s++) begin
            sub = SW'(den_reg[s-1]) << (QW - s);
            q_next[s] = q_reg[s-1];
            if (SW'(rem_reg[s-1]) >= sub) begin
                q_next[s][QW-s] = 1'b1;
                if (s < QW) begin
                    rem_next[s] = rem_reg[s-1] - sub[REM_W-1:0];
                end
            end else if (s < QW) begin
                rem_next[s] = rem_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= {in_mag, F'(0)};
            q_reg[0]   <= '0;
            den_reg[0] <= in_den;
            neg_reg[0] <= in_neg;
            ovf_reg[0] <= ovf_next;
            ctx_reg[0] <= in_ctx;
            for (int s = 1; s <= QW; s++) begin
                q_reg[s]   <= q_next[s];
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                ctx_reg[s] <= ctx_reg[s-1];
                if (s < QW) begin
                    rem_reg[s] <= rem_next[s];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_q     = ovf_reg[QW] ? '1 : q_reg[QW];
    assign out_neg   = neg_reg[QW];
    assign out_ctx   = ctx_reg[QW];

endmodule

// File: rtl/ntr_exp2_unit.sv
// Pipelined fractional exp2 unit, one constant multiplication per stage.
module ntr_exp2_unit
    import ntr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [F-1:0]        in_frac,
    input  ectx_t               in_ectx,
    output logic                out_valid,
    output logic [MANT_W-1:0]   out_y,
    output ectx_t               out_ectx
);

    logic [F:0]             valid_reg;
    logic [MANT_W-1:0]      y_reg    [0:F];
    logic [F-1:0]           frac_reg [0:F-1];
    ectx_t                  ectx_reg [0:F];
    logic [MANT_W-1:0]      y_next   [1:F];

    always_comb begin
        for (int j = 1; j <= F; j++) begin
            y_next[j] = y_reg[j-1];
            if (frac_reg[j-1][F-j]) begin
                y_next[j] = exp_mul(y_reg[j-1], EXP_C[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[F-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg[0]    <= MANT_W'(1) << Q;
            frac_reg[0] <= in_frac;
            ectx_reg[0] <= in_ectx;
            for (int j = 1; j <= F; j++) begin
                y_reg[j]    <= y_next[j];
                ectx_reg[j] <= ectx_reg[j-1];
                if (j < F) begin
                    frac_reg[j] <= frac_reg[j-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[F];
    assign out_y     = y_reg[F];
    assign out_ectx  = ectx_reg[F];

endmodule

// File: rtl/nonlinear_thermal_time_response_top.sv
// Top level of the pipelined nonlinear thermal time response block.
//
// Usage: each transaction on the s_ channel carries one cell-day (maximum and
// minimum temperature, signed 1/256 degC). Each input transaction produces
// exactly one transaction on the m_ channel with the day's degree-days in
// m_tdata and a status code in m_tuser (0 in range, 1 mean outside range,
// 2 inconsistent configuration). Results come out in input order.
// Pipeline stages: one input stage, 17 log2 stages (normalize, then one
// mantissa squaring each), one prepare stage, 23 divider stages (load, then
// one quotient bit each), one select stage, 17 exp2 stages (load, then one
// constant multiply each), and three output stages for the final products.
// Unless stalled, it accepts a transaction and gives a result every cycle.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. The cfg channel is always
// ready; the user must write only while idle; the block does not enforce it.
// Reset clears all valid bits and loads the default configuration.
module nonlinear_thermal_time_response_top
    import ntr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // max_temperature, min_temperature
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // degree_days
    output logic [1:0]          m_tuser,   // status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [TEMP_W-1:0]   cfg_data
);

    logic adv;

    logic [TEMP_W-1:0] base_reg, opt_reg, max_reg;

    logic signed [TEMP_W-1:0] tmax, tmin, avg, b, o, mx;
    logic signed [TEMP_W:0]   sum, d_full, x_full, bigd_full;
    status_t                  st0_next;

    logic                       s0_valid_reg;
    logic [2:0][TEMP_W-1:0]     s0_v_reg;
    ctx_t                       s0_ctx_reg;

    logic                       lg_valid;
    logic [2:0][LOG_W-1:0]      lg_log;
    ctx_t                       lg_ctx;

    logic [LOG_W-1:0]           diff, den_next, mag_next;
    logic                       neg_next;
    logic                       p_valid_reg;
    logic [LOG_W-1:0]           p_mag_reg, p_den_reg;
    logic                       p_neg_reg;
    ctx_t                       p_ctx_reg;

    logic                       dv_valid;
    logic [QW-1:0]              dv_q;
    logic                       dv_neg;
    ctx_t                       dv_ctx;

    logic [QW-1:0]              qq;
    ectx_t                      e_ectx_next;
    logic                       e_valid_reg;
    logic [F-1:0]               e_frac_reg;
    ectx_t                      e_ectx_reg;

    logic                       ex_valid;
    logic [MANT_W-1:0]          ex_y;
    ectx_t                      ex_ectx;

    logic [MANT_W-1:0]          y_shift;
    logic [YW-1:0]              y_next;
    logic                       y_valid_reg;
    logic [YW-1:0]              y_reg;
    ctx_t                       y_ctx_reg;

    logic [FW-1:0]              f_next;
    logic                       f_valid_reg;
    logic [FW-1:0]              f_reg;
    ctx_t                       f_ctx_reg;

    logic [TEMP_W+FW-1:0]       dd_prod;
    logic [TEMP_W-1:0]          dd_next;
    logic                       m_tvalid_reg;
    logic [TEMP_W-1:0]          m_dd_reg;
    status_t                    m_status_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= TEMP_W'(0);
            opt_reg  <= TEMP_W'(6400);
            max_reg  <= TEMP_W'(10240);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE: base_reg <= cfg_data;
                REG_OPT:  opt_reg  <= cfg_data;
                REG_MAX:  max_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        tmax      = s_tdata[TEMP_W-1:0];
        tmin      = s_tdata[2*TEMP_W-1:TEMP_W];
        b         = base_reg;
        o         = opt_reg;
        mx        = max_reg;
        sum       = {tmax[TEMP_W-1], tmax} + {tmin[TEMP_W-1], tmin};
        avg       = sum[TEMP_W:1];
        d_full    = {o[TEMP_W-1], o} - {b[TEMP_W-1], b};
        x_full    = {avg[TEMP_W-1], avg} - {b[TEMP_W-1], b};
        bigd_full = {mx[TEMP_W-1], mx} - {b[TEMP_W-1], b};
        if (o <= b || mx <= o) begin
            st0_next = ST_CONFIG;
        end else if (avg <= b || avg >= mx) begin
            st0_next = ST_RANGE;
        end else begin
            st0_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_v_reg[0]       <= d_full[TEMP_W-1:0];
            s0_v_reg[1]       <= x_full[TEMP_W-1:0];
            s0_v_reg[2]       <= bigd_full[TEMP_W-1:0];
            s0_ctx_reg.status <= st0_next;
            s0_ctx_reg.d      <= d_full[TEMP_W-1:0];
        end
    end

    ntr_log2_unit u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s0_valid_reg),
        .in_v      (s0_v_reg),
        .in_ctx    (s0_ctx_reg),
        .out_valid (lg_valid),
        .out_log   (lg_log),
        .out_ctx   (lg_ctx)
    );

    always_comb begin
        diff     = lg_log[2] - lg_log[0];
        den_next = (diff == '0) ? LOG_W'(1) : diff;
        neg_next = lg_log[1] < lg_log[0];
        mag_next = neg_next ? lg_log[0] - lg_log[1] : lg_log[1] - lg_log[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= lg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_mag_reg <= mag_next;
            p_den_reg <= den_next;
            p_neg_reg <= neg_next;
            p_ctx_reg <= lg_ctx;
        end
    end

    ntr_div_unit u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p_valid_reg),
        .in_mag    (p_mag_reg),
        .in_den    (p_den_reg),
        .in_neg    (p_neg_reg),
        .in_ctx    (p_ctx_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_neg   (dv_neg),
        .out_ctx   (dv_ctx)
    );

    always_comb begin
        qq = dv_neg ? Q_LIM - dv_q : Q_LIM + dv_q;
        e_ectx_next.ctx = dv_ctx;
        e_ectx_next.n   = NW'(qq[QW-1:F]);
        if (!dv_neg && dv_q >= Q_ONE) begin
            e_ectx_next.mode = Y_TWO_SAT;
        end else if (dv_neg && dv_q >= Q_LIM) begin
            e_ectx_next.mode = Y_ZERO;
        end else begin
            e_ectx_next.mode = Y_EXP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_frac_reg <= qq[F-1:0];
            e_ectx_reg <= e_ectx_next;
        end
    end

    ntr_exp2_unit u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (e_valid_reg),
        .in_frac   (e_frac_reg),
        .in_ectx   (e_ectx_reg),
        .out_valid (ex_valid),
        .out_y     (ex_y),
        .out_ectx  (ex_ectx)
    );

    always_comb begin
        y_shift = ex_y >> (MANT_W - int'(ex_ectx.n));
        case (ex_ectx.mode)
            Y_TWO_SAT: y_next = Y_TWO;
            Y_ZERO:    y_next = '0;
            default:   y_next = (y_shift > MANT_W'(Y_TWO)) ? Y_TWO : y_shift[YW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            y_valid_reg <= ex_valid;
            f_valid_reg <= y_valid_reg;
        end
    end

    assign f_next = FW'(y_reg) * FW'(Y_TWO - y_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg     <= y_next;
            y_ctx_reg <= ex_ectx.ctx;
            f_reg     <= f_next;
            f_ctx_reg <= y_ctx_reg;
        end
    end

    always_comb begin
        dd_prod = (TEMP_W+FW)'(f_ctx_reg.d) * (TEMP_W+FW)'(f_reg);
        dd_next = (f_ctx_reg.status == ST_OK) ? dd_prod[2*F+TEMP_W-1:2*F] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_dd_reg     <= dd_next;
            m_status_reg <= f_ctx_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_dd_reg};
    assign m_tuser  = m_status_reg;

    a_zero_when_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero degree-days with a non-ok status");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the pipeline is stalled");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the thermal time response block: directed and random cell-days.
module testbench
    import ntr_pkg::*;
();

    localparam int LF = LOG_FRAC_BITS;
    localparam int LATENCY = 70;

    typedef struct {
        logic [14:0] tmax;
        logic [14:0] tmin;
        bit          known;
        logic [14:0] dd;
        status_t     st;
    } day_row_t;

    typedef struct {
        logic [14:0] dd;
        status_t     st;
    } response_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    logic [14:0] base_t;
    logic [14:0] opt_t;
    logic [14:0] max_t;
    response_t   pending_responses[$];
    int          error_count;
    int          random_count;
    int          stall_left;

    nonlinear_thermal_time_response_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic longint unsigned log2_q(int unsigned v);
        int unsigned     e;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        m = longint'(v) << (30 - e);
        for (int i = 0; i < LF; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) << LF) | frac;
    endfunction

    function automatic longint unsigned pow2_frac_q30(longint unsigned f);
        longint unsigned y;
        longint unsigned c;
        y = 64'd1 << 30;
        c = root_floor(64'd1 << 61);
        for (int j = 1; j <= LF; j++) begin
            if ((f >> (LF - j)) & 1) y = (y * c) >> 30;
            c = root_floor(c << 30);
        end
        return y;
    endfunction

    function automatic response_t predict_day(logic [14:0] tmax, logic [14:0] tmin);
        response_t       r;
        int              b;
        int              o;
        int              mx;
        int              avg;
        longint unsigned one;
        longint unsigned lim;
        longint unsigned d;
        longint unsigned ld;
        longint unsigned lx;
        longint unsigned lspan;
        longint unsigned mag;
        longint unsigned qm;
        longint unsigned qq;
        longint unsigned y;
        bit              neg;
        b = $signed(base_t);
        o = $signed(opt_t);
        mx = $signed(max_t);
        avg = ($signed(tmax) + $signed(tmin)) >>> 1;
        r.dd = '0;
        one = 64'd1 << LF;
        lim = longint'(LF + 1) << LF;
        if (o <= b || mx <= o) begin
            r.st = ST_CONFIG;
        end else if (avg <= b || avg >= mx) begin
            r.st = ST_RANGE;
        end else begin
            r.st = ST_OK;
            d = o - b;
            ld = log2_q(o - b);
            lx = log2_q(avg - b);
            lspan = log2_q(mx - b) - ld;
            if (lspan == 0) lspan = 1;
            neg = lx < ld;
            mag = neg ? ld - lx : lx - ld;
            qm = (mag << LF) / lspan;
            if (!neg && qm >= one) begin
                y = 2 * one;
            end else if (neg && qm >= lim) begin
                y = 0;
            end else begin
                qq = neg ? lim - qm : lim + qm;
                y = pow2_frac_q30(qq & (one - 1)) >> (31 - (qq >> LF));
            end
            if (y > 2 * one) y = 2 * one;
            r.dd = 15'((d * (y * (2 * one - y))) >> (2 * LF));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", m_tdata));
            end else begin
                response_t e;
                e = pending_responses.pop_front();
                if (m_tdata != {1'b0, e.dd})
                    report_mismatch($sformatf("degree_days %0d, want %0d", m_tdata, e.dd));
                if (m_tuser != e.st)
                    report_mismatch($sformatf("status %0d, want %0d", m_tuser, e.st));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_day(logic [14:0] tmax, logic [14:0] tmin, bit known,
                            logic [14:0] dd, status_t st);
        response_t r;
        int        gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {2'b0, tmin, tmax};
        s_tvalid <= 1'b1;
        r = predict_day(tmax, tmin);
        if (known) begin
            r.dd = dd;
            r.st = st;
        end
        pending_responses.push_back(r);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(reg_index_t idx, logic [14:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_BASE) base_t = val;
        else if (idx == REG_OPT) opt_t = val;
        else max_t = val;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic configure(logic [14:0] b, logic [14:0] o, logic [14:0] m);
        drain();
        write_reg(REG_BASE, b);
        write_reg(REG_OPT, o);
        write_reg(REG_MAX, m);
        cfg_valid <= 1'b0;
    endtask

    // Mostly temperatures near the response window, some anywhere.
    task automatic random_days(int count);
        int lo;
        int hi;
        int t1;
        int t2;
        lo = $signed(base_t) - 512;
        hi = $signed(max_t) + 512;
        if (lo < -16384) lo = -16384;
        if (hi > 16383) hi = 16383;
        for (int i = 0; i < count; i++) begin
            if (lo < hi && $urandom_range(0, 4) != 0) begin
                t1 = lo + $urandom_range(0, hi - lo);
                t2 = t1 + $signed($urandom_range(0, 512)) - 256;
                if (t2 < -16384) t2 = -16384;
                if (t2 > 16383) t2 = 16383;
                send_day(15'(t1), 15'(t2), 1'b0, '0, ST_OK);
            end else begin
                send_day(15'($urandom), 15'($urandom), 1'b0, '0, ST_OK);
            end
            random_count++;
        end
    endtask

    day_row_t directed_days[] = '{
        '{15'd6400, 15'd6400, 1'b1, 15'd6400, ST_OK},
        '{15'd0, 15'd0, 1'b1, 15'd0, ST_RANGE},
        '{15'd10240, 15'd10240, 1'b1, 15'd0, ST_RANGE},
        '{15'h3FFF, 15'h3FFF, 1'b1, 15'd0, ST_RANGE},
        '{15'h4000, 15'h4000, 1'b1, 15'd0, ST_RANGE},
        '{15'h4000, 15'h3FFF, 1'b1, 15'd0, ST_RANGE},
        '{15'd1, 15'd2, 1'b0, 15'd0, ST_OK},
        '{15'd1, 15'd1, 1'b0, 15'd0, ST_OK},
        '{15'd10239, 15'd10239, 1'b0, 15'd0, ST_OK},
        '{15'd10239, 15'd10240, 1'b0, 15'd0, ST_OK},
        '{15'd3000, 15'd5000, 1'b0, 15'd0, ST_OK},
        '{15'd8000, 15'd9000, 1'b0, 15'd0, ST_OK},
        '{15'h2AAA, 15'h5555, 1'b0, 15'd0, ST_OK},
        '{15'h5555, 15'h2AAA, 1'b0, 15'd0, ST_OK},
        '{15'h7FFF, 15'd1, 1'b1, 15'd0, ST_RANGE}
    };

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        base_t = 15'd0;
        opt_t = 15'd6400;
        max_t = 15'd10240;
        error_count = 0;
        random_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_days[i])
            send_day(directed_days[i].tmax, directed_days[i].tmin, directed_days[i].known,
                     directed_days[i].dd, directed_days[i].st);
        configure(15'd100, 15'd101, 15'd102);
        random_days(150);
        configure(15'h4000, 15'h4001, 15'h3FFF);
        random_days(150);
        configure(15'd500, 15'd500, 15'd9000);
        send_day(15'd1000, 15'd1000, 1'b1, 15'd0, ST_CONFIG);
        configure(15'd500, 15'd6000, 15'd6000);
        send_day(15'd1000, 15'd1000, 1'b1, 15'd0, ST_CONFIG);
        configure(15'h4000, 15'd0, 15'h3FFF);
        random_days(300);
        configure(15'd1280, 15'd7680, 15'd11520);
        random_days(350);
        configure(15'h7000, 15'h0500, 15'h0600);
        random_days(250);
        configure(15'h4000, 15'h3FFE, 15'h3FFF);
        random_days(250);
        configure(15'h7F00, 15'd10, 15'd8000);
        random_days(300);
        configure(15'd0, 15'd6400, 15'd10240);
        random_days(250);
        drain();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
